FILE: design/ubxfc_pkg.sv
// Package: parser phases, sync and class codes, verdict codes for the frame checker.
`default_nettype none

package ubxfc_pkg;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_IDENT   = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_SUM_A   = 4'd7,
        PH_SUM_B   = 4'd8,
        PH_DONE    = 4'd9
    } phase_t;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] CLASS_ACK   = 8'h05;
    localparam logic [7:0] CLASS_CFG   = 8'h06;
    localparam logic [7:0] CLASS_NAV   = 8'h01;
    localparam logic [7:0] ID_ACK      = 8'h01;
    localparam logic [7:0] ID_NAK      = 8'h00;
    localparam logic [15:0] ACK_LENGTH = 16'd2;

    localparam logic [2:0] TYPE_NONE      = 3'd0;
    localparam logic [2:0] TYPE_ACK       = 3'd1;
    localparam logic [2:0] TYPE_NAK       = 3'd2;
    localparam logic [2:0] TYPE_ACK_OTHER = 3'd3;
    localparam logic [2:0] TYPE_CFG       = 3'd4;
    localparam logic [2:0] TYPE_NAV       = 3'd5;
    localparam logic [2:0] TYPE_OTHER     = 3'd6;

    localparam logic [1:0] VAL_UNDEFINED = 2'd0;
    localparam logic [1:0] VAL_INVALID   = 2'd1;
    localparam logic [1:0] VAL_VALID     = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SYNC      = 3'd1;
    localparam logic [2:0] ERR_ACK_LEN   = 3'd2;
    localparam logic [2:0] ERR_ZERO_LEN  = 3'd3;
    localparam logic [2:0] ERR_MISMATCH  = 3'd4;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd7;

    localparam logic RES_PAYLOAD = 1'b0;
    localparam logic RES_VERDICT = 1'b1;

    localparam logic [2:0] REG_REQ_CLASS = 3'd0;
    localparam logic [2:0] REG_REQ_ID    = 3'd4;

endpackage

`default_nettype wire

FILE: design/ubx_frame_check_parser_unit.sv
// Top level: byte-wise binary frame parser with header check and Fletcher-8 checksum.
//
// Input channel (in_valid/in_ready) takes one received byte per word, with
// last_of_read marking the final byte of a read; the byte after it is taken
// as the first sync byte of a new frame. Output channel (out_valid/out_ready)
// gives payload bytes of accepted frames (result_kind 0) and one verdict per
// frame (result_kind 1) with frame type, validity and error cause.
// Each word is decoded combinationally between the phase and sum registers and
// the output register; a result appears on the output in the cycle after its
// input word is accepted. Throughput is one word per cycle while the receiver
// takes results, as the phase and running sums update with each accepted word.
// in_ready is high while the output register is empty or being emptied, so
// a stalled receiver holds its result and stops input once that register is full.
// Reset returns the parser to the first sync byte, clears the held header and
// sums, empties the output register and clears requested_class and
// requested_id. The APB port sets requested_class at address 0 and
// requested_id at address 4; write it only while the block is idle.
`default_nettype none

module ubx_frame_check_parser_unit #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        last_of_read,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic      [7:0]  payload_value,
    output logic      [7:0]  payload_position,
    output logic      [7:0]  frame_class,
    output logic      [7:0]  frame_ident,
    output logic      [15:0] frame_length,
    output logic      [2:0]  frame_type,
    output logic      [1:0]  validity,
    output logic      [2:0]  error_cause
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    logic [7:0] req_class_reg;
    logic [7:0] req_id_reg;

    ubxfc_pkg::phase_t phase_reg, phase_next, step_phase;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [7:0]  held_class_reg, held_class_next;
    logic [7:0]  held_ident_reg, held_ident_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  recv_a_reg, recv_a_next;
    logic [2:0]  held_type_reg, held_type_next;

    logic [7:0]  sum_a_add, sum_b_add;
    logic [15:0] hdr_len;
    logic        is_ack, is_req, hdr_accept, sum_match;
    logic [2:0]  hdr_type, hdr_cause;

    logic        res_valid;
    logic        res_kind;
    logic [7:0]  res_value, res_pos;
    logic [2:0]  res_type, res_cause;
    logic [1:0]  res_validity;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_value_reg, out_pos_reg, out_class_reg, out_ident_reg;
    logic [15:0] out_length_reg;
    logic [2:0]  out_type_reg, out_cause_reg;
    logic [1:0]  out_validity_reg;

    logic        accept;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {24'h0, (paddr[2] ? req_id_reg : req_class_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_class_reg <= 8'h0;
            req_id_reg    <= 8'h0;
        end
        else if (cfg_write)
        begin
            if ((paddr & 3'b100) == ubxfc_pkg::REG_REQ_CLASS)
            begin
                req_class_reg <= pwdata[7:0];
            end
            else if ((paddr & 3'b100) == ubxfc_pkg::REG_REQ_ID)
            begin
                req_id_reg <= pwdata[7:0];
            end
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign hdr_len   = {rx_byte, held_length_reg[7:0]};
    assign is_ack    = held_class_reg == ubxfc_pkg::CLASS_ACK;
    assign is_req    = (held_class_reg == req_class_reg) && (held_ident_reg == req_id_reg);
    assign sum_match = (recv_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);

    always_comb
    begin
        hdr_accept = 1'b0;
        hdr_type   = ubxfc_pkg::TYPE_NONE;
        hdr_cause  = ubxfc_pkg::ERR_MISMATCH;
        if (is_ack)
        begin
            hdr_cause  = ubxfc_pkg::ERR_ACK_LEN;
            hdr_accept = hdr_len == ubxfc_pkg::ACK_LENGTH;
            if (held_ident_reg == ubxfc_pkg::ID_ACK)
            begin
                hdr_type = ubxfc_pkg::TYPE_ACK;
            end
            else if (held_ident_reg == ubxfc_pkg::ID_NAK)
            begin
                hdr_type = ubxfc_pkg::TYPE_NAK;
            end
            else
            begin
                hdr_type = ubxfc_pkg::TYPE_ACK_OTHER;
            end
        end
        else if (is_req)
        begin
            if (hdr_len == 16'h0)
            begin
                hdr_cause = ubxfc_pkg::ERR_ZERO_LEN;
            end
            else if ({1'b0, hdr_len} > MAX_LEN)
            begin
                hdr_cause = ubxfc_pkg::ERR_TOO_LONG;
            end
            else
            begin
                hdr_accept = 1'b1;
            end
            if (held_class_reg == ubxfc_pkg::CLASS_CFG)
            begin
                hdr_type = ubxfc_pkg::TYPE_CFG;
            end
            else if (held_class_reg == ubxfc_pkg::CLASS_NAV)
            begin
                hdr_type = ubxfc_pkg::TYPE_NAV;
            end
            else
            begin
                hdr_type = ubxfc_pkg::TYPE_OTHER;
            end
        end
    end

    // next phase
    always_comb
    begin
        unique case (phase_reg)
            ubxfc_pkg::PH_SYNC1:
                step_phase = (rx_byte == ubxfc_pkg::SYNC_FIRST) ?
                             ubxfc_pkg::PH_SYNC2 : ubxfc_pkg::PH_DONE;
            ubxfc_pkg::PH_SYNC2:
                step_phase = (rx_byte == ubxfc_pkg::SYNC_SECOND) ?
                             ubxfc_pkg::PH_CLASS : ubxfc_pkg::PH_DONE;
            ubxfc_pkg::PH_CLASS:   step_phase = ubxfc_pkg::PH_IDENT;
            ubxfc_pkg::PH_IDENT:   step_phase = ubxfc_pkg::PH_LEN_LO;
            ubxfc_pkg::PH_LEN_LO:  step_phase = ubxfc_pkg::PH_LEN_HI;
            ubxfc_pkg::PH_LEN_HI:
                step_phase = hdr_accept ? ubxfc_pkg::PH_PAYLOAD : ubxfc_pkg::PH_DONE;
            ubxfc_pkg::PH_PAYLOAD:
                step_phase = (16'(cnt_inc) >= held_length_reg) ?
                             ubxfc_pkg::PH_SUM_A : ubxfc_pkg::PH_PAYLOAD;
            ubxfc_pkg::PH_SUM_A:   step_phase = ubxfc_pkg::PH_SUM_B;
            ubxfc_pkg::PH_SUM_B:   step_phase = ubxfc_pkg::PH_DONE;
            ubxfc_pkg::PH_DONE:    step_phase = ubxfc_pkg::PH_DONE;
            default:               step_phase = ubxfc_pkg::PH_DONE;
        endcase
        phase_next = last_of_read ? ubxfc_pkg::PH_SYNC1 : step_phase;
    end

    // held fields and result
    always_comb
    begin
        cnt_next         = cnt_reg;
        held_class_next  = held_class_reg;
        held_ident_next  = held_ident_reg;
        held_length_next = held_length_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        recv_a_next      = recv_a_reg;
        held_type_next   = held_type_reg;
        res_valid        = 1'b0;
        res_kind         = ubxfc_pkg::RES_VERDICT;
        res_value        = 8'h0;
        res_pos          = 8'h0;
        res_type         = ubxfc_pkg::TYPE_NONE;
        res_validity     = ubxfc_pkg::VAL_UNDEFINED;
        res_cause        = ubxfc_pkg::ERR_NONE;

        unique case (phase_reg)
            ubxfc_pkg::PH_SYNC1:
            begin
                cnt_next         = '0;
                held_class_next  = 8'h0;
                held_ident_next  = 8'h0;
                held_length_next = 16'h0;
                sum_a_next       = 8'h0;
                sum_b_next       = 8'h0;
                recv_a_next      = 8'h0;
                held_type_next   = ubxfc_pkg::TYPE_NONE;
                if (rx_byte != ubxfc_pkg::SYNC_FIRST)
                begin
                    res_valid = 1'b1;
                    res_cause = ubxfc_pkg::ERR_SYNC;
                end
            end
            ubxfc_pkg::PH_SYNC2:
            begin
                if (rx_byte != ubxfc_pkg::SYNC_SECOND)
                begin
                    res_valid = 1'b1;
                    res_cause = ubxfc_pkg::ERR_SYNC;
                end
            end
            ubxfc_pkg::PH_CLASS:
            begin
                held_class_next = rx_byte;
                sum_a_next      = sum_a_add;
                sum_b_next      = sum_b_add;
            end
            ubxfc_pkg::PH_IDENT:
            begin
                held_ident_next = rx_byte;
                sum_a_next      = sum_a_add;
                sum_b_next      = sum_b_add;
            end
            ubxfc_pkg::PH_LEN_LO:
            begin
                held_length_next = {8'h0, rx_byte};
                sum_a_next       = sum_a_add;
                sum_b_next       = sum_b_add;
            end
            ubxfc_pkg::PH_LEN_HI:
            begin
                held_length_next = hdr_len;
                sum_a_next       = sum_a_add;
                sum_b_next       = sum_b_add;
                if (hdr_accept)
                begin
                    held_type_next = hdr_type;
                end
                else
                begin
                    res_valid    = 1'b1;
                    res_validity = ubxfc_pkg::VAL_INVALID;
                    res_cause    = hdr_cause;
                end
            end
            ubxfc_pkg::PH_PAYLOAD:
            begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                cnt_next   = cnt_inc;
                res_valid  = 1'b1;
                res_kind   = ubxfc_pkg::RES_PAYLOAD;
                res_value  = rx_byte;
                res_pos    = 8'(cnt_reg);
            end
            ubxfc_pkg::PH_SUM_A:
            begin
                recv_a_next = rx_byte;
            end
            ubxfc_pkg::PH_SUM_B:
            begin
                res_valid    = 1'b1;
                res_type     = held_type_reg;
                res_validity = sum_match ? ubxfc_pkg::VAL_VALID : ubxfc_pkg::VAL_INVALID;
                res_cause    = sum_match ? ubxfc_pkg::ERR_NONE : ubxfc_pkg::ERR_CHECKSUM;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        // truncated read overrides any payload word of this step
        if (last_of_read && (step_phase != ubxfc_pkg::PH_DONE))
        begin
            res_valid    = 1'b1;
            res_kind     = ubxfc_pkg::RES_VERDICT;
            res_value    = 8'h0;
            res_pos      = 8'h0;
            res_type     = held_type_next;
            res_validity = ubxfc_pkg::VAL_INVALID;
            res_cause    = ubxfc_pkg::ERR_TRUNCATED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ubxfc_pkg::PH_SYNC1;
            cnt_reg         <= '0;
            held_class_reg  <= 8'h0;
            held_ident_reg  <= 8'h0;
            held_length_reg <= 16'h0;
            sum_a_reg       <= 8'h0;
            sum_b_reg       <= 8'h0;
            recv_a_reg      <= 8'h0;
            held_type_reg   <= ubxfc_pkg::TYPE_NONE;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            held_class_reg  <= held_class_next;
            held_ident_reg  <= held_ident_next;
            held_length_reg <= held_length_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            recv_a_reg      <= recv_a_next;
            held_type_reg   <= held_type_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_kind_reg     <= res_kind;
            out_value_reg    <= res_value;
            out_pos_reg      <= res_pos;
            out_class_reg    <= held_class_next;
            out_ident_reg    <= held_ident_next;
            out_length_reg   <= held_length_next;
            out_type_reg     <= res_type;
            out_validity_reg <= res_validity;
            out_cause_reg    <= res_cause;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = out_kind_reg;
    assign payload_value    = out_value_reg;
    assign payload_position = out_pos_reg;
    assign frame_class      = out_class_reg;
    assign frame_ident      = out_ident_reg;
    assign frame_length     = out_length_reg;
    assign frame_type       = out_type_reg;
    assign validity         = out_validity_reg;
    assign error_cause      = out_cause_reg;

endmodule

`default_nettype wire

FILE: tb/ubx_frame_check_parser_unit_tb.sv
// Testbench for the frame check parser: stimulus table, random frames, predictor scoring.
`timescale 1ns / 1ps

module ubx_frame_check_parser_unit_tb;

    localparam int PAYLOAD_LIMIT = 256;
    localparam int PHASE_ITEMS = 225;
    localparam int PHASE_COUNT = 6;
    localparam int DRAIN_LIMIT = 2000;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value;
        logic [7:0]  pos;
        logic [7:0]  cls;
        logic [7:0]  ident;
        logic [15:0] len;
        logic [2:0]  ftype;
        logic [1:0]  valid;
        logic [2:0]  cause;
    } result_t;

    typedef struct {
        logic [7:0] b;
        logic       l;
        bit         typed;
        result_t    r;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = '0;
    logic        last_of_read = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        result_kind;
    logic [7:0]  payload_value;
    logic [7:0]  payload_position;
    logic [7:0]  frame_class;
    logic [7:0]  frame_ident;
    logic [15:0] frame_length;
    logic [2:0]  frame_type;
    logic [1:0]  validity;
    logic [2:0]  error_cause;

    logic [7:0]  req_cls = '0;
    logic [7:0]  req_id = '0;
    ubxfc_pkg::phase_t ph = ubxfc_pkg::PH_SYNC1;
    logic [15:0] cnt = '0;
    logic [7:0]  h_cls = '0;
    logic [7:0]  h_id = '0;
    logic [15:0] h_len = '0;
    logic [7:0]  sum_a = '0;
    logic [7:0]  sum_b = '0;
    logic [7:0]  rx_sum_a = '0;
    logic [2:0]  h_type = '0;

    result_t     due_words[$];
    table_row_t  rows[$];
    int          err_count = 0;
    int          sent_items = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          send_gaps = 1'b1;
    bit          recv_stalls = 1'b1;

    ubx_frame_check_parser_unit #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .last_of_read(last_of_read),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_kind(result_kind),
        .payload_value(payload_value),
        .payload_position(payload_position),
        .frame_class(frame_class),
        .frame_ident(frame_ident),
        .frame_length(frame_length),
        .frame_type(frame_type),
        .validity(validity),
        .error_cause(error_cause)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic result_t verdict(input logic [7:0] c, input logic [7:0] i,
                                        input logic [15:0] n, input logic [2:0] t,
                                        input logic [1:0] v, input logic [2:0] e);
        result_t r;
        r = '0;
        r.kind = ubxfc_pkg::RES_VERDICT;
        r.cls = c;
        r.ident = i;
        r.len = n;
        r.ftype = t;
        r.valid = v;
        r.cause = e;
        return r;
    endfunction

    function automatic void fold_sum(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic l, output result_t r);
        bit has;
        has = 1'b0;
        r = '0;
        case (ph)
            ubxfc_pkg::PH_SYNC1:
            begin
                cnt = '0;
                h_cls = '0;
                h_id = '0;
                h_len = '0;
                sum_a = '0;
                sum_b = '0;
                rx_sum_a = '0;
                h_type = '0;
                if (b != ubxfc_pkg::SYNC_FIRST)
                begin
                    r = verdict(h_cls, h_id, h_len, ubxfc_pkg::TYPE_NONE,
                                ubxfc_pkg::VAL_UNDEFINED, ubxfc_pkg::ERR_SYNC);
                    has = 1'b1;
                    ph = ubxfc_pkg::PH_DONE;
                end
                else
                    ph = ubxfc_pkg::PH_SYNC2;
            end
            ubxfc_pkg::PH_SYNC2:
            begin
                if (b != ubxfc_pkg::SYNC_SECOND)
                begin
                    r = verdict(h_cls, h_id, h_len, ubxfc_pkg::TYPE_NONE,
                                ubxfc_pkg::VAL_UNDEFINED, ubxfc_pkg::ERR_SYNC);
                    has = 1'b1;
                    ph = ubxfc_pkg::PH_DONE;
                end
                else
                    ph = ubxfc_pkg::PH_CLASS;
            end
            ubxfc_pkg::PH_CLASS:
            begin
                h_cls = b;
                fold_sum(b);
                ph = ubxfc_pkg::PH_IDENT;
            end
            ubxfc_pkg::PH_IDENT:
            begin
                h_id = b;
                fold_sum(b);
                ph = ubxfc_pkg::PH_LEN_LO;
            end
            ubxfc_pkg::PH_LEN_LO:
            begin
                h_len = {8'h00, b};
                fold_sum(b);
                ph = ubxfc_pkg::PH_LEN_HI;
            end
            ubxfc_pkg::PH_LEN_HI:
            begin
                h_len[15:8] = b;
                fold_sum(b);
                ph = ubxfc_pkg::PH_DONE;
                if (h_cls == ubxfc_pkg::CLASS_ACK)
                begin
                    if (h_len != ubxfc_pkg::ACK_LENGTH)
                    begin
                        r = verdict(h_cls, h_id, h_len, ubxfc_pkg::TYPE_NONE,
                                    ubxfc_pkg::VAL_INVALID, ubxfc_pkg::ERR_ACK_LEN);
                        has = 1'b1;
                    end
                    else
                    begin
                        h_type = (h_id == ubxfc_pkg::ID_ACK) ? ubxfc_pkg::TYPE_ACK :
                                 (h_id == ubxfc_pkg::ID_NAK) ? ubxfc_pkg::TYPE_NAK :
                                 ubxfc_pkg::TYPE_ACK_OTHER;
                        ph = ubxfc_pkg::PH_PAYLOAD;
                    end
                end
                else if (h_cls == req_cls && h_id == req_id)
                begin
                    if (h_len == 16'd0)
                    begin
                        r = verdict(h_cls, h_id, h_len, ubxfc_pkg::TYPE_NONE,
                                    ubxfc_pkg::VAL_INVALID, ubxfc_pkg::ERR_ZERO_LEN);
                        has = 1'b1;
                    end
                    else if (h_len > PAYLOAD_LIMIT)
                    begin
                        r = verdict(h_cls, h_id, h_len, ubxfc_pkg::TYPE_NONE,
                                    ubxfc_pkg::VAL_INVALID, ubxfc_pkg::ERR_TOO_LONG);
                        has = 1'b1;
                    end
                    else
                    begin
                        h_type = (h_cls == ubxfc_pkg::CLASS_CFG) ? ubxfc_pkg::TYPE_CFG :
                                 (h_cls == ubxfc_pkg::CLASS_NAV) ? ubxfc_pkg::TYPE_NAV :
                                 ubxfc_pkg::TYPE_OTHER;
                        ph = ubxfc_pkg::PH_PAYLOAD;
                    end
                end
                else
                begin
                    r = verdict(h_cls, h_id, h_len, ubxfc_pkg::TYPE_NONE,
                                ubxfc_pkg::VAL_INVALID, ubxfc_pkg::ERR_MISMATCH);
                    has = 1'b1;
                end
            end
            ubxfc_pkg::PH_PAYLOAD:
            begin
                fold_sum(b);
                r.kind = ubxfc_pkg::RES_PAYLOAD;
                r.value = b;
                r.pos = cnt[7:0];
                r.cls = h_cls;
                r.ident = h_id;
                r.len = h_len;
                has = 1'b1;
                cnt = cnt + 16'd1;
                if (cnt >= h_len)
                    ph = ubxfc_pkg::PH_SUM_A;
            end
            ubxfc_pkg::PH_SUM_A:
            begin
                rx_sum_a = b;
                ph = ubxfc_pkg::PH_SUM_B;
            end
            ubxfc_pkg::PH_SUM_B:
            begin
                if (rx_sum_a == sum_a && b == sum_b)
                    r = verdict(h_cls, h_id, h_len, h_type,
                                ubxfc_pkg::VAL_VALID, ubxfc_pkg::ERR_NONE);
                else
                    r = verdict(h_cls, h_id, h_len, h_type,
                                ubxfc_pkg::VAL_INVALID, ubxfc_pkg::ERR_CHECKSUM);
                has = 1'b1;
                ph = ubxfc_pkg::PH_DONE;
            end
            default:
                ph = ubxfc_pkg::PH_DONE;
        endcase
        if (l)
        begin
            if (ph != ubxfc_pkg::PH_DONE)
            begin
                r = verdict(h_cls, h_id, h_len, h_type,
                            ubxfc_pkg::VAL_INVALID, ubxfc_pkg::ERR_TRUNCATED);
                has = 1'b1;
            end
            ph = ubxfc_pkg::PH_SYNC1;
        end
        return has;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic score_word(input result_t got);
        result_t want;
        if (due_words.size() == 0)
        begin
            flag_mismatch("word with nothing due, result_kind", got.kind, '0);
            return;
        end
        want = due_words.pop_front();
        if (got.kind !== want.kind)
            flag_mismatch("result_kind", got.kind, want.kind);
        if (got.value !== want.value)
            flag_mismatch("payload_value", got.value, want.value);
        if (got.pos !== want.pos)
            flag_mismatch("payload_position", got.pos, want.pos);
        if (got.cls !== want.cls)
            flag_mismatch("frame_class", got.cls, want.cls);
        if (got.ident !== want.ident)
            flag_mismatch("frame_ident", got.ident, want.ident);
        if (got.len !== want.len)
            flag_mismatch("frame_length", got.len, want.len);
        if (got.ftype !== want.ftype)
            flag_mismatch("frame_type", got.ftype, want.ftype);
        if (got.valid !== want.valid)
            flag_mismatch("validity", got.valid, want.valid);
        if (got.cause !== want.cause)
            flag_mismatch("error_cause", got.cause, want.cause);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            score_word({result_kind, payload_value, payload_position, frame_class, frame_ident,
                        frame_length, frame_type, validity, error_cause});
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (recv_stalls && $urandom_range(0, 6) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                             input result_t typed_word);
        result_t guess;
        bit has;
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        last_of_read <= l;
        do @(posedge clk); while (!in_ready);
        sent_items++;
        has = parse_byte(b, l, guess);
        if (typed)
            due_words.push_back(typed_word);
        else if (has)
            due_words.push_back(guess);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (due_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (due_words.size() != 0)
        begin
            flag_mismatch("words never delivered, count", 16'(due_words.size()), '0);
            due_words.delete();
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ubxfc_pkg::REG_REQ_CLASS)
            req_cls = val;
        else
            req_id = val;
        @(posedge clk);
    endtask

    task automatic send_frame();
        logic [7:0]  fb[$];
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [7:0]  ca;
        logic [7:0]  cb;
        logic [15:0] len;
        int          pick;
        int          hdr;
        int          n;
        int          cut;
        int          at;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)),
                          (i == n - 1) || ($urandom_range(0, 3) == 0), 1'b0, '0);
            return;
        end
        hdr = $urandom_range(0, 99);
        if (hdr < 25)
        begin
            cls = ubxfc_pkg::CLASS_ACK;
            case ($urandom_range(0, 2))
                0: id = ubxfc_pkg::ID_ACK;
                1: id = ubxfc_pkg::ID_NAK;
                default: id = 8'($urandom_range(0, 255));
            endcase
            len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 8)) :
                  ubxfc_pkg::ACK_LENGTH;
        end
        else if (hdr < 80)
        begin
            cls = req_cls;
            id = req_id;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                len = 16'd0;
            else if (pick < 5)
                len = 16'(PAYLOAD_LIMIT);
            else if (pick < 7)
                len = 16'($urandom_range(13, 64));
            else if (pick < 10)
                len = 16'($urandom_range(PAYLOAD_LIMIT + 1, 65535));
            else if (pick < 11)
                len = 16'hFFFF;
            else
                len = 16'($urandom_range(1, 12));
        end
        else
        begin
            cls = 8'($urandom_range(0, 255));
            id = 8'($urandom_range(0, 255));
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        end
        n = (hdr >= 80 || len > PAYLOAD_LIMIT) ? $urandom_range(0, 2) : int'(len);
        fb = '{ubxfc_pkg::SYNC_FIRST, ubxfc_pkg::SYNC_SECOND, cls, id, len[7:0], len[15:8]};
        for (int i = 0; i < n; i++)
            fb.push_back(8'($urandom_range(0, 255)));
        ca = '0;
        cb = '0;
        for (int i = 2; i < fb.size(); i++)
        begin
            ca = ca + fb[i];
            cb = cb + ca;
        end
        if ($urandom_range(0, 7) == 0)
            ca = ca ^ (8'd1 << $urandom_range(0, 7));
        if ($urandom_range(0, 7) == 0)
            cb = cb ^ (8'd1 << $urandom_range(0, 7));
        fb.push_back(ca);
        fb.push_back(cb);
        if ($urandom_range(0, 24) == 0)
        begin
            at = $urandom_range(0, 1);
            fb[at] = fb[at] ^ 8'($urandom_range(1, 255));
        end
        pick = $urandom_range(0, 99);
        if (pick < 12)
            repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom_range(0, 255)));
        cut = (pick >= 88) ? $urandom_range(0, fb.size() - 2) : fb.size() - 1;
        for (int i = 0; i <= cut; i++)
            send_byte(fb[i], i == cut, 1'b0, '0);
    endtask

    function automatic void add_row(input logic [7:0] b, input logic l);
        rows.push_back('{b, l, 1'b0, '0});
    endfunction

    function automatic void add_typed(input logic [7:0] b, input logic l, input result_t r);
        rows.push_back('{b, l, 1'b1, r});
    endfunction

    initial
    begin
        logic [7:0] cfg_cls;
        logic [7:0] cfg_id;

        add_typed(8'h00, 1'b1, verdict('0, '0, '0, ubxfc_pkg::TYPE_NONE,
                                       ubxfc_pkg::VAL_UNDEFINED, ubxfc_pkg::ERR_SYNC));
        add_typed(ubxfc_pkg::SYNC_FIRST, 1'b1,
                  verdict('0, '0, '0, ubxfc_pkg::TYPE_NONE,
                          ubxfc_pkg::VAL_INVALID, ubxfc_pkg::ERR_TRUNCATED));
        add_row(ubxfc_pkg::SYNC_FIRST, 1'b0);
        add_typed(8'hFF, 1'b1, verdict('0, '0, '0, ubxfc_pkg::TYPE_NONE,
                                       ubxfc_pkg::VAL_UNDEFINED, ubxfc_pkg::ERR_SYNC));
        add_row(ubxfc_pkg::SYNC_FIRST, 1'b0);
        add_row(ubxfc_pkg::SYNC_SECOND, 1'b0);
        add_row(ubxfc_pkg::CLASS_ACK, 1'b0);
        add_row(ubxfc_pkg::ID_NAK, 1'b0);
        add_row(8'h03, 1'b0);
        add_typed(8'h00, 1'b1,
                  verdict(ubxfc_pkg::CLASS_ACK, ubxfc_pkg::ID_NAK, 16'h0003,
                          ubxfc_pkg::TYPE_NONE, ubxfc_pkg::VAL_INVALID,
                          ubxfc_pkg::ERR_ACK_LEN));
        add_row(ubxfc_pkg::SYNC_FIRST, 1'b0);
        add_row(ubxfc_pkg::SYNC_SECOND, 1'b0);
        add_row(8'hAA, 1'b0);
        add_row(8'hBB, 1'b0);
        add_row(8'h00, 1'b0);
        add_typed(8'hFF, 1'b1,
                  verdict(8'hAA, 8'hBB, 16'hFF00, ubxfc_pkg::TYPE_NONE,
                          ubxfc_pkg::VAL_INVALID, ubxfc_pkg::ERR_MISMATCH));
        add_row(ubxfc_pkg::SYNC_FIRST, 1'b0);
        add_row(ubxfc_pkg::SYNC_SECOND, 1'b0);
        add_row(ubxfc_pkg::CLASS_ACK, 1'b0);
        add_row(ubxfc_pkg::ID_ACK, 1'b0);
        add_row(8'h02, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(ubxfc_pkg::CLASS_CFG, 1'b0);
        add_row(8'h01, 1'b0);
        add_row(8'h0F, 1'b0);
        add_row(8'h38, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_byte(rows[i].b, rows[i].l, rows[i].typed, rows[i].r);
        settle();

        sent_items = 0;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin cfg_cls = 8'h00; cfg_id = 8'h00; end
                1: begin cfg_cls = 8'hFF; cfg_id = 8'hFF; end
                2: begin cfg_cls = ubxfc_pkg::CLASS_CFG; cfg_id = 8'($urandom_range(0, 255)); end
                3: begin cfg_cls = ubxfc_pkg::CLASS_NAV; cfg_id = 8'($urandom_range(0, 255)); end
                default:
                begin
                    cfg_cls = 8'($urandom_range(0, 255));
                    cfg_id = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(ubxfc_pkg::REG_REQ_CLASS, cfg_cls);
            write_reg(ubxfc_pkg::REG_REQ_ID, cfg_id);
            send_gaps = (p != 2) && (p != PHASE_COUNT - 1);
            recv_stalls = (p != 3) && (p != PHASE_COUNT - 1);
            while (sent_items < (p + 1) * PHASE_ITEMS)
            begin
                if ($urandom_range(0, 39) == 0)
                    settle();
                send_frame();
            end
            settle();
        end

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
